[rtl/core/swcd_pkg.sv]
// Shared types, constants and the CRC-8 function of the sensor word decoder.
package swcd_pkg;

  localparam logic [7:0]  CRC_INIT     = 8'hFF;
  localparam logic [7:0]  CRC_POLY     = 8'h31;
  localparam logic [7:0]  TEMP_SCALE   = 8'd175;
  localparam logic [16:0] TEMP_DIVISOR = 17'd65535;
  localparam logic [25:0] FRAC_ROUND   = 26'd32767;
  localparam logic [9:0]  MILLI        = 10'd1000;
  localparam logic [17:0] TEMP_OFFSET  = 18'd45000;

  localparam logic [2:0] IDX_FIRST_CRC  = 3'd2;
  localparam logic [2:0] IDX_SECOND_HI  = 3'd3;
  localparam logic [2:0] IDX_SECOND_CRC = 3'd5;

  localparam logic KIND_TEMP   = 1'b0;
  localparam logic KIND_SERIAL = 1'b1;

  typedef struct packed {
    logic        bad;
    logic        serial;
    logic [31:0] word;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_WHOLE,
    BK_SCALE,
    BK_DIV_FRAC,
    BK_FINISH
  } back_state_e;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/swcd_in_if.sv]
// Byte input channel with valid/ready handshake.
interface swcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

[rtl/core/swcd_out_if.sv]
// Result output channel with valid/ready handshake.
interface swcd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [17:0] temperature_milli_c;
  logic [31:0]        serial_word;

  modport source (output valid, output status, output temperature_milli_c,
                  output serial_word, input ready);
  modport sink (input valid, input status, input temperature_milli_c,
                input serial_word, output ready);
endinterface

[rtl/core/swcd_front.sv]
// Front end: frames the bytes, checks word CRCs and issues one job per frame.
module swcd_front
  import swcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  swcd_in_if.sink   rx_i,
  input  logic      frame_kind_i,
  input  logic      full_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [2:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] word_q, word_d;
  logic [15:0] first_word_q, first_word_d;
  logic        first_good_q, first_good_d;
  logic        done_q, done_d;

  logic        accept;
  logic        active;
  logic [2:0]  idx;
  logic [7:0]  crc;
  logic [15:0] wrd;
  logic [15:0] fword;
  logic        fgood;
  logic        good;

  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign active     = rx_i.frame_start || !done_q;

  always_comb begin
    idx   = rx_i.frame_start ? 3'd0 : byte_idx_q;
    crc   = rx_i.frame_start ? CRC_INIT : crc_q;
    wrd   = rx_i.frame_start ? 16'd0 : word_q;
    fword = rx_i.frame_start ? 16'd0 : first_word_q;
    fgood = rx_i.frame_start ? 1'b0 : first_good_q;
    good  = (crc == rx_i.rx_byte);

    byte_idx_d   = byte_idx_q;
    crc_d        = crc_q;
    word_d       = word_q;
    first_word_d = first_word_q;
    first_good_d = first_good_q;
    done_d       = done_q;
    push_o       = 1'b0;
    job_o        = '{bad: 1'b0, serial: frame_kind_i, word: {fword, wrd}};

    if (accept && active) begin
      byte_idx_d   = idx;
      crc_d        = crc;
      word_d       = wrd;
      first_word_d = fword;
      first_good_d = fgood;
      done_d       = 1'b0;
      if (idx != IDX_FIRST_CRC && idx != IDX_SECOND_CRC) begin
        crc_d      = crc8_byte(crc, rx_i.rx_byte);
        word_d     = {wrd[7:0], rx_i.rx_byte};
        byte_idx_d = idx + 3'd1;
      end else if (idx == IDX_FIRST_CRC && frame_kind_i == KIND_SERIAL) begin
        crc_d        = CRC_INIT;
        first_word_d = wrd;
        first_good_d = good;
        word_d       = 16'd0;
        byte_idx_d   = IDX_SECOND_HI;
      end else begin
        crc_d      = CRC_INIT;
        push_o     = 1'b1;
        job_o.bad  = !(good && (idx != IDX_SECOND_CRC || fgood));
        done_d     = 1'b1;
        byte_idx_d = 3'd0;
        word_d     = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q   <= 3'd0;
      crc_q        <= CRC_INIT;
      word_q       <= 16'd0;
      first_word_q <= 16'd0;
      first_good_q <= 1'b0;
      done_q       <= 1'b1;
    end else begin
      byte_idx_q   <= byte_idx_d;
      crc_q        <= crc_d;
      word_q       <= word_d;
      first_word_q <= first_word_d;
      first_good_q <= first_good_d;
      done_q       <= done_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |=> done_q)
    else $error("A finished frame did not leave the front end done.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) byte_idx_q <= IDX_SECOND_CRC)
    else $error("Byte position ran past the last CRC byte.");
`endif

endmodule

[rtl/core/swcd_queue.sv]
// Small job queue between the front end and the conversion back end.
module swcd_queue
  import swcd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Job pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");
`endif

endmodule

[rtl/core/swcd_back.sv]
// Back end: converts temperature ticks through its multiply, divide, scale and finish states and holds the result.
module swcd_back
  import swcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      q_job_i,
  output logic      pop_o,
  swcd_out_if.source res_o
);

  back_state_e state_q, state_d;

  job_t               job_q;
  logic [25:0]        acc_q;
  logic [15:0]        rem_q;
  logic [7:0]         whole_q;
  logic [9:0]         frac_q;
  logic signed [17:0] temp_q;
  logic               emit_pending_q;

  logic               out_valid_q;
  logic               out_status_q;
  logic signed [17:0] out_temp_q;
  logic [31:0]        out_serial_q;

  logic               out_free;
  logic               emit;
  logic [16:0]        fold_sum;
  logic               fold_carry;
  logic [9:0]         fold_quo;
  logic [15:0]        fold_rem;
  logic [23:0]        ticks_prod;
  logic [25:0]        frac_num;
  logic [17:0]        temp_sum;

  // Division by 65535 adds the high part into the low part and corrects once.
  assign out_free   = !out_valid_q || res_o.ready;
  assign fold_sum   = {7'd0, acc_q[25:16]} + {1'b0, acc_q[15:0]};
  assign fold_carry = (fold_sum >= TEMP_DIVISOR);
  assign fold_quo   = acc_q[25:16] + {9'd0, fold_carry};
  assign fold_rem   = fold_carry ? 16'(fold_sum - TEMP_DIVISOR) : fold_sum[15:0];
  assign ticks_prod = 24'(job_q.word[15:0]) * 24'(TEMP_SCALE);
  assign frac_num   = ({10'd0, rem_q} * 26'(MILLI)) + FRAC_ROUND;
  assign temp_sum   = ({10'd0, whole_q} * 18'(MILLI)) + 18'(frac_q) - TEMP_OFFSET;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && !emit_pending_q) begin
          state_d = (q_job_i.bad || q_job_i.serial) ? BK_IDLE : BK_MUL;
        end
      end
      BK_MUL:       state_d = BK_DIV_WHOLE;
      BK_DIV_WHOLE: state_d = BK_SCALE;
      BK_SCALE:     state_d = BK_DIV_FRAC;
      BK_DIV_FRAC:  state_d = BK_FINISH;
      BK_FINISH:    state_d = BK_IDLE;
      default:      state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == BK_IDLE) && q_valid_i && !emit_pending_q;
    emit  = (state_q == BK_IDLE) && emit_pending_q && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= q_job_i;
      temp_q <= '0;
    end
    case (state_q)
      BK_MUL: acc_q <= 26'(ticks_prod);
      BK_DIV_WHOLE: begin
        whole_q <= fold_quo[7:0];
        rem_q   <= fold_rem;
      end
      BK_SCALE:    acc_q <= frac_num;
      BK_DIV_FRAC: frac_q <= fold_quo;
      BK_FINISH:   temp_q <= signed'(temp_sum);
      default: begin
      end
    endcase
    if (emit) begin
      out_status_q <= job_q.bad;
      out_temp_q   <= temp_q;
      out_serial_q <= (!job_q.bad && job_q.serial) ? job_q.word : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      emit_pending_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        emit_pending_q <= 1'b0;
      end else if ((pop_o && (q_job_i.bad || q_job_i.serial)) || state_q == BK_FINISH) begin
        emit_pending_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.status              = out_status_q;
  assign res_o.temperature_milli_c = out_temp_q;
  assign res_o.serial_word         = out_serial_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_temp_q == '0 && out_serial_q == '0))
    else $error("Failed frame carries a nonzero value.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FINISH) |-> (frac_q <= MILLI && whole_q <= TEMP_SCALE))
    else $error("Conversion quotient out of range.");
`endif

endmodule

[rtl/core/sensor_word_crc_and_temp_decode.sv]
// Top level: sensor response decoder with CRC-8 word checks and temperature conversion.
// Bytes are accepted one per cycle while the job queue has room; the front end never stalls
// a byte otherwise. A frame ends on its last CRC byte: a serial or failed frame gives its
// result via the queue and the back end's output register, a temperature frame also after
// the five-step conversion of the back end. Each job is issued before the next is popped.
// Reset is asynchronous and active low: kind is temperature, and the decoder waits for a start.
module sensor_word_crc_and_temp_decode
  import swcd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swcd_in_if.sink    rx_i,
  swcd_out_if.source res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic kind_q;
  logic push;
  job_t push_job;
  logic full;
  logic q_valid;
  job_t q_job;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_TEMP;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  swcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .frame_kind_i (kind_q),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  swcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .valid_o    (q_valid),
    .job_o      (q_job),
    .pop_i      (pop)
  );

  swcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule
